### design/ddm_pkg.sv
// Shared types, constants and fixed-point scale factors of the differential drive mixer.
`default_nettype none

package ddm_pkg;

  localparam int PERMILLE_FULL      = 1000;
  localparam int INNER_MIN_PERMILLE = 300;
  localparam int PERCENT_FULL       = 100;

  localparam int CMD_W   = 16;  // raw command width
  localparam int PMIL_W  = 11;  // signed permille, -1000..1000
  localparam int SUM_W   = 12;  // signed sum or difference, -2000..2000
  localparam int WIDE_W  = 13;  // signed sum plus or minus limited difference
  localparam int MAG_W   = 11;  // magnitude of the sum, 0..2000
  localparam int PCT_W   = 8;   // signed percent
  localparam int PMAG_W  = 10;  // magnitude of a permille value, 0..1000
  localparam int PQ_W    = 7;   // magnitude of a percent, 0..100

  // |sum| * 700 / 1300 as a multiply by a rounded-up reciprocal and a shift.
  localparam int LIMIT_SHIFT = 18;
  localparam int LIMIT_NUM   = PERMILLE_FULL - INNER_MIN_PERMILLE;
  localparam int LIMIT_DEN   = PERMILLE_FULL + INNER_MIN_PERMILLE;
  localparam int LIMIT_MUL   = (LIMIT_NUM * (2 ** LIMIT_SHIFT) + LIMIT_DEN - 1) / LIMIT_DEN;
  localparam int LIMIT_MUL_W = 18;
  localparam int LIMIT_PROD_W = MAG_W + LIMIT_MUL_W;

  // value * 100 / 1000 on a magnitude up to 1000, same technique.
  localparam int PCT_SHIFT  = 11;
  localparam int PCT_MUL    = (PERCENT_FULL * (2 ** PCT_SHIFT) + PERMILLE_FULL - 1) /
                              PERMILLE_FULL;
  localparam int PCT_MUL_W  = 8;
  localparam int PCT_PROD_W = PMAG_W + PCT_MUL_W;

  typedef enum logic [2:0] {
    MC_STOP         = 3'd0,
    MC_FORWARD      = 3'd1,
    MC_BACKWARD     = 3'd2,
    MC_ROTATE_LEFT  = 3'd3,
    MC_ROTATE_RIGHT = 3'd4,
    MC_TURN_LEFT    = 3'd5,
    MC_TURN_RIGHT   = 3'd6
  } motion_class_t;

  // Limited wheel pair in permille, passed from the limiting stage to the scaling stage.
  typedef struct packed {
    logic signed [PMIL_W-1:0] left;
    logic signed [PMIL_W-1:0] right;
  } ddm_pair_t;

endpackage

`default_nettype wire

### design/differential_drive_mixer.sv
// Top level of the differential drive mixer: three-register pipeline with valid/stall flow.
//
// The mixer takes one item per clock: a signed left and right wheel command in
// permille. Each command is saturated to plus or minus 1000; unless the pair are
// exact opposites (a pivot, or both zero), the wheel difference is clamped to
// 7/13 of the absolute sum so the inner wheel keeps at least 30 percent of the
// outer one, and each side is rebuilt from sum and difference, all divisions
// truncating toward zero. The result item carries both sides in percent and a
// seven-way motion class computed from the limited values. An item passes an
// input register, a stage register after the limiting multiply and a result
// register, in that order, before it is on the outputs. One item is accepted
// every cycle as long as out_stall is low; a stalled result fills the stages
// behind it, and in_stall rises only when all three registers hold items. The
// rate of one item per cycle is set by the handshake alone; the constant
// multiply in each stage only bounds how short the clock period can be.
`default_nettype none

module differential_drive_mixer
  import ddm_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,

  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [CMD_W-1:0] in_left_command,
  input  wire logic signed [CMD_W-1:0] in_right_command,

  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [PCT_W-1:0]      out_left_drive,
  output logic signed [PCT_W-1:0]      out_right_drive,
  output logic [2:0]                   out_motion_class
);

  // Input register stage.
  logic                    in_vld_r;
  logic signed [CMD_W-1:0] left_cmd_r;
  logic signed [CMD_W-1:0] right_cmd_r;

  // Limited pair stage.
  logic                    mid_vld_r;
  ddm_pair_t               pair_r;
  ddm_pair_t               pair_nxt;

  // Result register stage.
  logic                    out_vld_r;
  logic signed [PCT_W-1:0] left_pct_r;
  logic signed [PCT_W-1:0] right_pct_r;
  motion_class_t           class_r;
  logic signed [PCT_W-1:0] left_pct_nxt;
  logic signed [PCT_W-1:0] right_pct_nxt;
  motion_class_t           class_nxt;

  // A stage may load when it is empty or its item moves on in the same cycle.
  logic adv_out;
  logic adv_mid;
  logic adv_in;

  assign adv_out  = !out_vld_r || !out_stall;
  assign adv_mid  = !mid_vld_r || adv_out;
  assign adv_in   = !in_vld_r  || adv_mid;
  assign in_stall = !adv_in;

  ddm_limit u_limit (
    .left_command  (left_cmd_r),
    .right_command (right_cmd_r),
    .pair          (pair_nxt)
  );

  ddm_scale u_scale (
    .pair          (pair_r),
    .left_drive    (left_pct_nxt),
    .right_drive   (right_pct_nxt),
    .motion_class  (class_nxt)
  );

  // Valid bits are control state and get cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      mid_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (adv_in) begin
        in_vld_r <= in_valid;
      end
      if (adv_mid) begin
        mid_vld_r <= in_vld_r;
      end
      if (adv_out) begin
        out_vld_r <= mid_vld_r;
      end
    end
  end

  // Payload registers load only when their stage advances, so a stalled item holds.
  always_ff @(posedge clk) begin
    if (adv_in) begin
      left_cmd_r  <= in_left_command;
      right_cmd_r <= in_right_command;
    end
    if (adv_mid) begin
      pair_r <= pair_nxt;
    end
    if (adv_out) begin
      left_pct_r  <= left_pct_nxt;
      right_pct_r <= right_pct_nxt;
      class_r     <= class_nxt;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_left_drive   = left_pct_r;
  assign out_right_drive  = right_pct_r;
  assign out_motion_class = class_r;

  // The input side only stalls when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && mid_vld_r && out_vld_r))
    else $error("in_stall raised while a pipeline stage was empty");

  // Results never leave the percent range.
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_drive >= -PCT_W'(PERCENT_FULL)
                   && out_left_drive <= PCT_W'(PERCENT_FULL)
                   && out_right_drive >= -PCT_W'(PERCENT_FULL)
                   && out_right_drive <= PCT_W'(PERCENT_FULL)))
    else $error("drive percent out of range");

  // A stop has both wheels at zero.
  a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_motion_class == MC_STOP) |->
      (out_left_drive == '0 && out_right_drive == '0))
    else $error("stop class with a nonzero wheel");

  // Straight motion drives both sides alike.
  a_straight_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_motion_class == MC_FORWARD || out_motion_class == MC_BACKWARD)) |->
      (out_left_drive == out_right_drive))
    else $error("straight motion with unequal wheels");

endmodule

`default_nettype wire

### design/ddm_limit.sv
// Saturation, inner wheel limiting and rebuild of the wheel pair in permille.
`default_nettype none

module ddm_limit
  import ddm_pkg::*;
(
  input  wire logic signed [CMD_W-1:0] left_command,
  input  wire logic signed [CMD_W-1:0] right_command,
  output ddm_pair_t                    pair
);

  logic signed [PMIL_W-1:0]       l_sat;
  logic signed [PMIL_W-1:0]       r_sat;
  logic signed [SUM_W-1:0]        sum;
  logic signed [SUM_W-1:0]        diff;
  logic        [MAG_W-1:0]        mag;
  logic        [LIMIT_PROD_W-1:0] prod;
  logic signed [WIDE_W-1:0]       lim;
  logic signed [WIDE_W-1:0]       diff_c;
  logic signed [WIDE_W-1:0]       lw;
  logic signed [WIDE_W-1:0]       rw;
  logic signed [WIDE_W-1:0]       lh;
  logic signed [WIDE_W-1:0]       rh;

  function automatic logic signed [PMIL_W-1:0] sat_pm(input logic signed [CMD_W-1:0] v);
    logic signed [PMIL_W-1:0] res;
    if (v > CMD_W'(PERMILLE_FULL)) begin
      res = PMIL_W'(PERMILLE_FULL);
    end else if (v < -CMD_W'(PERMILLE_FULL)) begin
      res = -PMIL_W'(PERMILLE_FULL);
    end else begin
      res = v[PMIL_W-1:0];
    end
    return res;
  endfunction

  assign l_sat = sat_pm(left_command);
  assign r_sat = sat_pm(right_command);

  assign sum  = SUM_W'(l_sat) + SUM_W'(r_sat);
  assign diff = SUM_W'(r_sat) - SUM_W'(l_sat);
  assign mag  = sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);

  assign prod = LIMIT_PROD_W'(mag) * LIMIT_PROD_W'(LIMIT_MUL);
  assign lim  = WIDE_W'(prod[LIMIT_PROD_W-1:LIMIT_SHIFT]);

  always_comb begin
    if (WIDE_W'(diff) > lim) begin
      diff_c = lim;
    end else if (WIDE_W'(diff) < -lim) begin
      diff_c = -lim;
    end else begin
      diff_c = WIDE_W'(diff);
    end
  end

  assign lw = WIDE_W'(sum) - diff_c;
  assign rw = WIDE_W'(sum) + diff_c;
  // Halving that truncates toward zero: bias negative values by one before the shift.
  assign lh = (lw + WIDE_W'(signed'({1'b0, lw[WIDE_W-1]}))) >>> 1;
  assign rh = (rw + WIDE_W'(signed'({1'b0, rw[WIDE_W-1]}))) >>> 1;

  // Exact opposites, both zero included, pass through unlimited.
  always_comb begin
    if (sum == '0) begin
      pair.left  = l_sat;
      pair.right = r_sat;
    end else begin
      pair.left  = lh[PMIL_W-1:0];
      pair.right = rh[PMIL_W-1:0];
    end
  end

endmodule

`default_nettype wire

### design/ddm_scale.sv
// Percent conversion and motion classification of the limited wheel pair.
`default_nettype none

module ddm_scale
  import ddm_pkg::*;
(
  input  wire ddm_pair_t              pair,
  output logic signed [PCT_W-1:0]     left_drive,
  output logic signed [PCT_W-1:0]     right_drive,
  output motion_class_t               motion_class
);

  function automatic logic signed [PCT_W-1:0] to_pct(input logic signed [PMIL_W-1:0] v);
    logic [PMAG_W-1:0]     a;
    logic [PCT_PROD_W-1:0] p;
    logic [PQ_W-1:0]       q;
    a = v[PMIL_W-1] ? PMAG_W'(-v) : PMAG_W'(v);
    p = PCT_PROD_W'(a) * PCT_PROD_W'(PCT_MUL);
    q = p[PCT_PROD_W-1:PCT_SHIFT];
    return v[PMIL_W-1] ? -PCT_W'(q) : PCT_W'(q);
  endfunction

  assign left_drive  = to_pct(pair.left);
  assign right_drive = to_pct(pair.right);

  // In the equal and opposite arms the left value is nonzero, so its sign bit decides.
  always_comb begin
    if (pair.left == '0 && pair.right == '0) begin
      motion_class = MC_STOP;
    end else if (pair.left == pair.right) begin
      motion_class = pair.left[PMIL_W-1] ? MC_BACKWARD : MC_FORWARD;
    end else if (pair.left == -pair.right) begin
      motion_class = pair.left[PMIL_W-1] ? MC_ROTATE_LEFT : MC_ROTATE_RIGHT;
    end else begin
      motion_class = (pair.right > pair.left) ? MC_TURN_LEFT : MC_TURN_RIGHT;
    end
  end

endmodule

`default_nettype wire
